>>> sv/phl_pkg.sv
// Package for the path heading lookahead block: constants, types and the CORDIC table.
package phl_pkg;

  localparam int LOOKAHEAD_MAX_DEF = 32;
  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int ATAN_LEN          = 24;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [1:0] REG_START_YAW = 2'd1;
  localparam logic [1:0] REG_MIN_DIST  = 2'd2;

  // Request sent from the sequencer to the heading unit.
  typedef struct packed {
    logic               start;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } hdg_req_t;

  // Status returned by the heading unit.
  typedef struct packed {
    logic        done;
    logic [15:0] angle;
  } hdg_rsp_t;

  // atan(2^-i) in units of turn / 2^32.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/path_heading_lookahead.sv
// Top level: point buffer, emit sequencer and yaw unwrap around a shared CORDIC.
// A point leaves once the configured lookahead count of later points is held, or at the path
// end flush; its result goes to the output register after the heading stage.
// Each emitted point is read, squared, compared and, unless the target is too close, sent
// through the CORDIC; the output register waits for out_tready. No input is taken meanwhile.
// Reset is synchronous active low: control registers return to reset values, no path open.
module path_heading_lookahead #(
  parameter int LOOKAHEAD_MAX = phl_pkg::LOOKAHEAD_MAX_DEF,
  parameter int CORDIC_STEPS  = phl_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64]
  input  logic [95:0]  in_tdata,
  input  logic         in_tlast,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: out_x[31:0], out_y[63:32], out_z[95:64], yaw[127:96]
  output logic [127:0] out_tdata,
  output logic         out_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import phl_pkg::*;

  localparam int DEPTH = LOOKAHEAD_MAX + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_RDC   = 10'b0000000100,
    S_RDG   = 10'b0000001000,
    S_SQ    = 10'b0000010000,
    S_MUL   = 10'b0000100000,
    S_CMP   = 10'b0001000000,
    S_CORD  = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [5:0]  la_cfg_r;
  logic [31:0] start_yaw_r, min_dist_r, prev_yaw_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] head_r;
  logic        in_path_r, flush_r, fin_r;
  logic [95:0] cur_r;
  logic signed [32:0] dx_r, dy_r;
  logic [63:0] sq_r;
  logic [64:0] sum;
  logic [31:0] ox_r, oy_r, oz_r, oyaw_r;
  logic        olast_r, ovalid_r;

  logic [CW-1:0] la;
  logic [AW-1:0] rd_addr, wr_addr, tgt_addr;
  logic [95:0]   rd_data;
  logic          wr_en;
  logic          take;
  logic [CW-1:0] cnt_base;
  hdg_req_t      hreq;
  hdg_rsp_t      hrsp;
  logic [15:0]   dang;
  logic [CW:0]   tgt_sum;
  logic [AW:0]   head_inc;
  logic signed [32:0] sq_op;
  logic [32:0]   sq_neg;
  logic [31:0]   sq_mag;
  logic [63:0]   sq_prod;

  // Effective lookahead clamped to one through LOOKAHEAD_MAX.
  always_comb begin
    if (la_cfg_r == 6'd0) begin
      la = CW'(1);
    end else if (32'(la_cfg_r) > LOOKAHEAD_MAX) begin
      la = CW'(LOOKAHEAD_MAX);
    end else begin
      la = CW'(la_cfg_r);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign take      = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Slot arithmetic modulo the ring depth. A point with a full lookahead behind it
  // targets that point; otherwise the flush targets the last point held.
  assign cnt_base = in_path_r ? cnt_r : '0;
  always_comb begin
    logic [CW:0] s;
    s = (CW+1)'(in_path_r ? head_r : '0) + (CW+1)'(cnt_base);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    wr_addr = AW'(s);
    if (cnt_r > la) tgt_sum = (CW+1)'(head_r) + (CW+1)'(la);
    else            tgt_sum = (CW+1)'(head_r) + (CW+1)'(cnt_r) - (CW+1)'(1);
    if (tgt_sum >= (CW+1)'(DEPTH)) tgt_sum = tgt_sum - (CW+1)'(DEPTH);
    tgt_addr = AW'(tgt_sum);
    head_inc = (AW+1)'(head_r) + (AW+1)'(1);
    if (head_inc >= (AW+1)'(DEPTH)) head_inc = '0;
  end

  // The current point is read first, the target in the next cycle.
  assign wr_en   = take;
  assign rd_addr = (state_r == S_RDG) ? tgt_addr : head_r;

  phl_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_ring (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(in_tdata),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign hreq.start = (state_r == S_CMP) && (sum > 65'(min_dist_r));
  assign hreq.dx    = dx_r;
  assign hreq.dy    = dy_r;

  phl_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .req(hreq), .rsp(hrsp)
  );

  // One squarer on the magnitude: dx squared in S_MUL, dy squared in S_CMP.
  assign sq_op   = (state_r == S_MUL) ? dx_r : dy_r;
  assign sq_neg  = -sq_op;
  assign sq_mag  = sq_op[32] ? sq_neg[31:0] : sq_op[31:0];
  assign sq_prod = 64'(sq_mag) * 64'(sq_mag);

  assign sum  = {1'b0, sq_r} + {1'b0, sq_prod};
  assign dang = hrsp.angle - prev_yaw_r[15:0];

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (take) state_nxt = S_CHECK;
      S_CHECK: begin
        if (cnt_r > la || (flush_r && cnt_r != '0)) state_nxt = S_RDC;
        else state_nxt = S_IDLE;
      end
      S_RDC:   state_nxt = S_RDG;
      S_RDG:   state_nxt = S_SQ;
      S_SQ:    state_nxt = S_MUL;
      S_MUL:   state_nxt = S_CMP;
      S_CMP:   state_nxt = (sum > 65'(min_dist_r)) ? S_CORD : S_OUT;
      S_CORD:  if (hrsp.done) state_nxt = S_OUT;
      S_OUT:   if (!ovalid_r || out_tready) state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_CHECK;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      la_cfg_r    <= 6'd5;
      start_yaw_r <= '0;
      min_dist_r  <= 32'd43;
      prev_yaw_r  <= '0;
      cnt_r       <= '0;
      head_r      <= '0;
      in_path_r   <= 1'b0;
      flush_r     <= 1'b0;
      ovalid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LOOKAHEAD: la_cfg_r    <= cfg_data[5:0];
          REG_START_YAW: start_yaw_r <= cfg_data;
          REG_MIN_DIST:  min_dist_r  <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        if (!in_path_r) begin
          prev_yaw_r <= start_yaw_r;
          head_r     <= '0;
        end
        cnt_r     <= cnt_base + CW'(1);
        in_path_r <= 1'b1;
        flush_r   <= in_tlast;
      end
      if (state_r == S_CHECK && state_nxt == S_IDLE && flush_r) begin
        head_r    <= '0;
        in_path_r <= 1'b0;
        flush_r   <= 1'b0;
      end
      if (state_r == S_CORD && hrsp.done) begin
        if (dang[15]) prev_yaw_r <= prev_yaw_r + {{16{1'b1}}, dang};
        else          prev_yaw_r <= prev_yaw_r + {16'd0, dang};
      end
      if (state_r == S_OUT && (!ovalid_r || out_tready)) begin
        ovalid_r <= 1'b1;
        head_r   <= AW'(head_inc);
        cnt_r    <= cnt_r - CW'(1);
      end else if (ovalid_r && out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) fin_r <= flush_r && cnt_r == CW'(1);
    if (state_r == S_RDG) cur_r <= rd_data;
    if (state_r == S_SQ) begin
      dx_r <= 33'(signed'(rd_data[31:0])) - 33'(signed'(cur_r[31:0]));
      dy_r <= 33'(signed'(rd_data[63:32])) - 33'(signed'(cur_r[63:32]));
    end
    if (state_r == S_MUL) sq_r <= sq_prod;
    if (state_r == S_OUT && (!ovalid_r || out_tready)) begin
      ox_r    <= cur_r[31:0];
      oy_r    <= cur_r[63:32];
      oz_r    <= cur_r[95:64];
      oyaw_r  <= prev_yaw_r;
      olast_r <= fin_r;
    end
  end

  assign out_tdata  = {oyaw_r, oz_r, oy_r, ox_r};
  assign out_tlast  = olast_r;
  assign out_tvalid = ovalid_r;

  // Held point count never exceeds the ring depth.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("point count beyond ring depth");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
  a_emit_has_point: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RDC |-> cnt_r != '0) else $error("emit with empty ring");
  a_cord_only_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    hreq.start |-> state_r == S_CMP) else $error("stray cordic start");
endmodule

>>> sv/phl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module phl_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

>>> sv/phl_cordic.sv
// Iterative vectoring CORDIC that returns the 16-bit binary angle of a vector.
module phl_cordic #(
  parameter int CORDIC_STEPS = phl_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  phl_pkg::hdg_req_t req,
  output phl_pkg::hdg_rsp_t rsp
);
  import phl_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int XW = 33 + NSTEP + 2;

  logic signed [XW-1:0] x_r, y_r;
  logic [31:0] ang_r;
  logic [4:0]  i_r;
  logic        busy_r, done_r;
  logic signed [XW-1:0] xs, ys;
  logic [31:0] ang_rnd;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign ang_rnd = ang_r + 32'h8000;

  // Pre-rotation into the right half plane, then one micro-rotation a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        if (req.dx < 0) begin
          if (req.dy >= 0) begin
            x_r <= XW'(req.dy);
            y_r <= -XW'(req.dx);
            ang_r <= 32'h4000_0000;
          end else begin
            x_r <= -XW'(req.dy);
            y_r <= XW'(req.dx);
            ang_r <= 32'hC000_0000;
          end
        end else begin
          x_r <= XW'(req.dx);
          y_r <= XW'(req.dy);
          ang_r <= 32'h0;
        end
      end else if (busy_r) begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          ang_r <= ang_r + atan_turn(i_r);
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          ang_r <= ang_r - atan_turn(i_r);
        end
        if (i_r == 5'(NSTEP - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        i_r <= i_r + 5'd1;
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.angle = ang_rnd[31:16];

  // A result is signalled only right after the last iteration.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> $past(busy_r)) else $error("cordic done without busy");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r) else $error("cordic busy and done together");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("cordic did not start");
endmodule
